/* design/csp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// shared types and constants of the sprite camera projection pipeline
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int CSP_QB      = 32;
    localparam int CSP_SCR_W   = 13;
    localparam int CSP_HALF_W  = 12;
    localparam int CSP_IDX_W   = 3;
    localparam int CSP_DATA_W  = 32;
    localparam int CSP_MAX_SCREEN = 4096;

    localparam logic [CSP_IDX_W-1:0] CFG_CAM_POS_X   = 3'd0;
    localparam logic [CSP_IDX_W-1:0] CFG_CAM_POS_Y   = 3'd1;
    localparam logic [CSP_IDX_W-1:0] CFG_VIEW_DIR_X  = 3'd2;
    localparam logic [CSP_IDX_W-1:0] CFG_VIEW_DIR_Y  = 3'd3;
    localparam logic [CSP_IDX_W-1:0] CFG_CAM_PLANE_X = 3'd4;
    localparam logic [CSP_IDX_W-1:0] CFG_CAM_PLANE_Y = 3'd5;
    localparam logic [CSP_IDX_W-1:0] CFG_SCREEN_W    = 3'd6;
    localparam logic [CSP_IDX_W-1:0] CFG_SCREEN_H    = 3'd7;

    typedef struct packed {
        logic signed [31:0] sprite_x;
        logic signed [31:0] sprite_y;
    } sprite_in_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [15:0] screen_col;
        logic [15:0]        sprite_size;
        logic [11:0]        first_row;
        logic signed [15:0] last_row;
        logic [14:0]        first_col;
        logic signed [15:0] last_col;
        logic               in_front;
        logic               depth_fault;
    } sprite_out_t;

    typedef struct packed {
        logic signed [31:0]   cam_pos_x;
        logic signed [31:0]   cam_pos_y;
        logic signed [31:0]   view_dir_x;
        logic signed [31:0]   view_dir_y;
        logic signed [31:0]   cam_plane_x;
        logic signed [31:0]   cam_plane_y;
        logic [CSP_SCR_W-1:0] screen_width;
        logic [CSP_SCR_W-1:0] screen_height;
    } cam_cfg_t;

    typedef struct packed {
        logic valid;
        logic fault;
        logic depth_neg;
        logic col_neg;
        logic in_front;
    } xf_flags_t;

    typedef struct packed {
        logic              ovf;
        logic [CSP_QB-1:0] q;
    } quo_t;

endpackage
`default_nettype wire

/* design/csp_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_regs
// camera and screen configuration registers with screen size clamping
// ----------------------------------------------------------------------------
module csp_regs #(
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [csp_pkg::CSP_IDX_W-1:0]   cfg_index,
    input  wire logic [csp_pkg::CSP_DATA_W-1:0]  cfg_data,
    output csp_pkg::cam_cfg_t                    cfg
);
    import csp_pkg::*;

    cam_cfg_t             cfg_reg;
    logic [CSP_SCR_W-1:0] scr_next;

    always_comb
    begin
        scr_next = cfg_data[CSP_SCR_W-1:0];
        if (scr_next == '0)
        begin
            scr_next = CSP_SCR_W'(1);
        end
        else if (32'(scr_next) > 32'(CSP_MAX_SCREEN))
        begin
            scr_next = CSP_SCR_W'(CSP_MAX_SCREEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_pos_x     <= '0;
            cfg_reg.cam_pos_y     <= '0;
            cfg_reg.view_dir_x    <= 32'(1) << FRAC_BITS;
            cfg_reg.view_dir_y    <= '0;
            cfg_reg.cam_plane_x   <= '0;
            cfg_reg.cam_plane_y   <= 32'sd43254;
            cfg_reg.screen_width  <= CSP_SCR_W'(640);
            cfg_reg.screen_height <= CSP_SCR_W'(480);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CAM_POS_X:   cfg_reg.cam_pos_x     <= cfg_data;
                CFG_CAM_POS_Y:   cfg_reg.cam_pos_y     <= cfg_data;
                CFG_VIEW_DIR_X:  cfg_reg.view_dir_x    <= cfg_data;
                CFG_VIEW_DIR_Y:  cfg_reg.view_dir_y    <= cfg_data;
                CFG_CAM_PLANE_X: cfg_reg.cam_plane_x   <= cfg_data;
                CFG_CAM_PLANE_Y: cfg_reg.cam_plane_y   <= cfg_data;
                CFG_SCREEN_W:    cfg_reg.screen_width  <= scr_next;
                CFG_SCREEN_H:    cfg_reg.screen_height <= scr_next;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* design/csp_xform.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_xform
// offset, camera transform and divider operand preparation, five stages
// ----------------------------------------------------------------------------
module csp_xform #(
    parameter int FRAC_BITS = 16,
    localparam int PW  = 65 - FRAC_BITS,
    localparam int NWD = PW + FRAC_BITS,
    localparam int NWC = PW + 1 + csp_pkg::CSP_HALF_W,
    localparam int NWS = PW + csp_pkg::CSP_SCR_W
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  csp_pkg::sprite_in_t      in_data,
    input  csp_pkg::cam_cfg_t        cfg,
    output logic [NWD-1:0]           num_depth,
    output logic [NWC-1:0]           num_col,
    output logic [NWS-1:0]           num_size,
    output logic [PW-1:0]            den_det,
    output logic [PW-1:0]            den_ny,
    output csp_pkg::xf_flags_t       flags
);
    import csp_pkg::*;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        begin
            d = {a[31], a} - {b[31], b};
            if (d[32] != d[31])
            begin
                return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            return d[31:0];
        end
    endfunction

    function automatic logic signed [PW-1:0] mul_fx(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = a * b;
            return PW'(p >>> FRAC_BITS);
        end
    endfunction

    // stage 1
    logic               v1_reg;
    logic signed [31:0] sx_reg, sy_reg;
    // stage 2
    logic               v2_reg;
    logic signed [PW-1:0] p_lxdy_reg, p_dxly_reg, p_dysx_reg;
    logic signed [PW-1:0] p_dxsy_reg, p_lxsy_reg, p_lysx_reg;
    // stage 3
    logic               v3_reg;
    logic signed [PW-1:0] det_reg, nx_reg, ny_reg;
    // stage 4
    xf_flags_t          f4_reg;
    logic [PW-1:0]      mdet_reg, mny_reg;
    logic [PW:0]        ms_reg;
    // stage 5
    xf_flags_t          f5_reg;
    logic [NWD-1:0]     nd_reg;
    logic [NWC-1:0]     nc_reg;
    logic [NWS-1:0]     ns_reg;
    logic [PW-1:0]      dd_reg, dn_reg;

    logic signed [PW:0] s_w;
    logic               fault_w;

    assign s_w     = {ny_reg[PW-1], ny_reg} + {nx_reg[PW-1], nx_reg};
    assign fault_w = (det_reg == '0) || (ny_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            f4_reg <= '0;
            f5_reg <= '0;
        end
        else if (en)
        begin
            v1_reg           <= in_valid;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            f4_reg.valid     <= v3_reg;
            f4_reg.fault     <= fault_w;
            f4_reg.depth_neg <= ny_reg[PW-1] ^ det_reg[PW-1];
            f4_reg.col_neg   <= s_w[PW] ^ ny_reg[PW-1];
            f4_reg.in_front  <= !fault_w && (ny_reg[PW-1] == det_reg[PW-1]);
            f5_reg           <= f4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg     <= sat_sub(in_data.sprite_x, cfg.cam_pos_x);
            sy_reg     <= sat_sub(in_data.sprite_y, cfg.cam_pos_y);
            p_lxdy_reg <= mul_fx(cfg.cam_plane_x, cfg.view_dir_y);
            p_dxly_reg <= mul_fx(cfg.view_dir_x, cfg.cam_plane_y);
            p_dysx_reg <= mul_fx(cfg.view_dir_y, sx_reg);
            p_dxsy_reg <= mul_fx(cfg.view_dir_x, sy_reg);
            p_lxsy_reg <= mul_fx(cfg.cam_plane_x, sy_reg);
            p_lysx_reg <= mul_fx(cfg.cam_plane_y, sx_reg);
            det_reg    <= p_lxdy_reg - p_dxly_reg;
            nx_reg     <= p_dysx_reg - p_dxsy_reg;
            ny_reg     <= p_lxsy_reg - p_lysx_reg;
            mdet_reg   <= det_reg[PW-1] ? PW'(-det_reg) : PW'(det_reg);
            mny_reg    <= ny_reg[PW-1] ? PW'(-ny_reg) : PW'(ny_reg);
            ms_reg     <= s_w[PW] ? (PW+1)'(-s_w) : (PW+1)'(s_w);
            nd_reg     <= {mny_reg, {FRAC_BITS{1'b0}}};
            nc_reg     <= NWC'(ms_reg) * NWC'(cfg.screen_width[CSP_SCR_W-1:1]);
            ns_reg     <= NWS'(mdet_reg) * NWS'(cfg.screen_height);
            dd_reg     <= mdet_reg;
            dn_reg     <= mny_reg;
        end
    end

    assign num_depth = nd_reg;
    assign num_col   = nc_reg;
    assign num_size  = ns_reg;
    assign den_det   = dd_reg;
    assign den_ny    = dn_reg;
    assign flags     = f5_reg;

endmodule
`default_nettype wire

/* design/csp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module csp_div #(
    parameter int NW = 65,
    parameter int DW = 49,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side,
    output csp_pkg::quo_t      quo,
    output logic [SW-1:0]      side_out
);
    import csp_pkg::*;

    localparam int QB = CSP_QB;
    localparam int TW = NW - QB;
    localparam int CW = (TW > DW) ? TW : DW;

    logic [DW-1:0] rem_reg  [QB+1];
    logic [QB-1:0] lo_reg   [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic [DW-1:0] den_reg  [QB+1];
    logic          ovf_reg  [QB+1];
    logic [SW-1:0] side_reg [QB+1];

    logic [CW-1:0] top_x, den_x;
    logic          ovf_w;

    assign top_x = CW'(num[NW-1:QB]);
    assign den_x = CW'(den);
    assign ovf_w = top_x >= den_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf_w ? '0 : DW'(top_x);
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_w;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [DW:0] t, diff;
        logic        ge;

        assign t    = {rem_reg[k-1], lo_reg[k-1][QB-1]};
        assign diff = t - {1'b0, den_reg[k-1]};
        assign ge   = t >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
                lo_reg[k]  <= {lo_reg[k-1][QB-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo.ovf  = ovf_reg[QB];
    assign quo.q    = q_reg[QB];
    assign side_out = side_reg[QB];

endmodule
`default_nettype wire

/* design/csp_bounds.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_bounds
// quotient saturation, draw bounds clamping and the output word register
// ----------------------------------------------------------------------------
module csp_bounds (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  csp_pkg::xf_flags_t flags,
    input  csp_pkg::quo_t      q_depth,
    input  csp_pkg::quo_t      q_col,
    input  csp_pkg::quo_t      q_size,
    input  csp_pkg::cam_cfg_t  cfg,
    output logic               out_valid,
    output csp_pkg::sprite_out_t out_data
);
    import csp_pkg::*;

    logic               va_reg, fault_a_reg, front_a_reg;
    logic signed [31:0] depth_a_reg;
    logic signed [15:0] col_a_reg;
    logic [15:0]        size_a_reg;
    logic               vb_reg;
    sprite_out_t        out_reg;

    logic signed [31:0] depth_w;
    logic signed [15:0] col_w;
    logic [15:0]        size_w;

    always_comb
    begin
        if (flags.depth_neg)
        begin
            // beyond full scale the negated cap wraps to the top value
            depth_w = (q_depth.ovf || q_depth.q > 32'h8000_0000) ? 32'sh7fff_ffff
                                                                  : -q_depth.q;
        end
        else
        begin
            depth_w = (q_depth.ovf || q_depth.q[31]) ? 32'sh7fff_ffff : q_depth.q;
        end
        if (flags.col_neg)
        begin
            col_w = (q_col.ovf || q_col.q > 32'd32768) ? 16'sh8000
                                                        : 16'(17'd0 - q_col.q[16:0]);
        end
        else
        begin
            col_w = (q_col.ovf || q_col.q > 32'd32767) ? 16'sh7fff : q_col.q[15:0];
        end
        size_w = (q_size.ovf || q_size.q > 32'd65535) ? 16'hffff : q_size.q[15:0];
        if (flags.fault)
        begin
            depth_w = '0;
            col_w   = '0;
            size_w  = '0;
        end
    end

    logic [14:0]        hs_w;
    logic [11:0]        hh_w;
    logic signed [17:0] r0_w, c0_w, c1_w;
    logic [16:0]        r1_w;
    sprite_out_t        out_next;

    always_comb
    begin
        hs_w = size_a_reg[15:1];
        hh_w = cfg.screen_height[CSP_SCR_W-1:1];
        r0_w = $signed({6'b0, hh_w}) - $signed({3'b0, hs_w});
        r1_w = {5'b0, hh_w} + {2'b0, hs_w};
        c0_w = {{2{col_a_reg[15]}}, col_a_reg} - $signed({3'b0, hs_w});
        c1_w = {{2{col_a_reg[15]}}, col_a_reg} + $signed({3'b0, hs_w});

        out_next             = '0;
        out_next.depth_fault = fault_a_reg;
        if (!fault_a_reg)
        begin
            out_next.depth       = depth_a_reg;
            out_next.screen_col  = col_a_reg;
            out_next.sprite_size = size_a_reg;
            out_next.in_front    = front_a_reg;
            out_next.first_row   = r0_w[17] ? '0 : r0_w[11:0];
            out_next.last_row    = (r1_w >= 17'(cfg.screen_height))
                                 ? 16'(cfg.screen_height - 13'd1) : 16'(r1_w);
            out_next.first_col   = c0_w[17] ? '0 : c0_w[14:0];
            out_next.last_col    = (c1_w >= $signed({5'b0, cfg.screen_width}))
                                 ? 16'(cfg.screen_width - 13'd1) : c1_w[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= flags.valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fault_a_reg <= flags.fault;
            front_a_reg <= flags.in_front;
            depth_a_reg <= depth_w;
            col_a_reg   <= col_w;
            size_a_reg  <= size_w;
            out_reg     <= out_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

/* design/camera_sprite_projection.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// camera_sprite_projection
// projects one sprite world position through the camera into screen terms
// ----------------------------------------------------------------------------
// Fully pipelined: one sprite word is taken every cycle while the output side
// keeps taking words. Three 33-stage dividers (an operand register, then one
// quotient bit per stage) run side by side, after five stages of offset,
// transform and operand set-up and before two stages of saturation, clamping
// and output register. A stall on the output freezes the whole pipeline, so
// nothing is dropped or repeated. Camera and screen registers are written
// through the plain write port and may only change while no sprite is in
// flight.
module camera_sprite_projection #(
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  csp_pkg::sprite_in_t                   in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output csp_pkg::sprite_out_t                  out_data,
    input  wire logic                             cfg_wr_en,
    input  wire logic [csp_pkg::CSP_IDX_W-1:0]   cfg_index,
    input  wire logic [csp_pkg::CSP_DATA_W-1:0]  cfg_data
);
    import csp_pkg::*;

    localparam int PW  = 65 - FRAC_BITS;
    localparam int NWD = PW + FRAC_BITS;
    localparam int NWC = PW + 1 + CSP_HALF_W;
    localparam int NWS = PW + CSP_SCR_W;

    cam_cfg_t       cfg;
    logic           adv;
    logic [NWD-1:0] num_depth;
    logic [NWC-1:0] num_col;
    logic [NWS-1:0] num_size;
    logic [PW-1:0]  den_det, den_ny;
    xf_flags_t      xf_flags, dv_flags;
    quo_t           q_depth, q_col, q_size;
    logic [2:0]     side_depth;
    logic           side_col, side_size;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    csp_regs #(
        .FRAC_BITS  (FRAC_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csp_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cfg       (cfg),
        .num_depth (num_depth),
        .num_col   (num_col),
        .num_size  (num_size),
        .den_det   (den_det),
        .den_ny    (den_ny),
        .flags     (xf_flags)
    );

    csp_div #(
        .NW (NWD),
        .DW (PW),
        .SW (3)
    ) u_div_depth (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num      (num_depth),
        .den      (den_det),
        .side     ({xf_flags.valid, xf_flags.depth_neg, xf_flags.in_front}),
        .quo      (q_depth),
        .side_out (side_depth)
    );

    csp_div #(
        .NW (NWC),
        .DW (PW),
        .SW (1)
    ) u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num      (num_col),
        .den      (den_ny),
        .side     (xf_flags.col_neg),
        .quo      (q_col),
        .side_out (side_col)
    );

    csp_div #(
        .NW (NWS),
        .DW (PW),
        .SW (1)
    ) u_div_size (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num      (num_size),
        .den      (den_ny),
        .side     (xf_flags.fault),
        .quo      (q_size),
        .side_out (side_size)
    );

    assign dv_flags.valid     = side_depth[2];
    assign dv_flags.depth_neg = side_depth[1];
    assign dv_flags.in_front  = side_depth[0];
    assign dv_flags.col_neg   = side_col;
    assign dv_flags.fault     = side_size;

    csp_bounds u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .flags     (dv_flags),
        .q_depth   (q_depth),
        .q_col     (q_col),
        .q_size    (q_size),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // fault word carries no geometry
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.depth_fault |->
            out_data.depth == '0 && out_data.screen_col == '0 &&
            out_data.sprite_size == '0 && out_data.first_row == '0)
        else $error("fault word with non-zero fields");

    a_front_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.in_front |-> !out_data.depth_fault)
        else $error("in_front set on a fault word");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with empty output");

    a_row_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed({out_data.last_row[15], out_data.last_row}) <
                      $signed({4'b0, cfg.screen_height}))
        else $error("last_row beyond screen height");

    a_col_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed({out_data.last_col[15], out_data.last_col}) <
                      $signed({4'b0, cfg.screen_width}))
        else $error("last_col beyond screen width");

endmodule
`default_nettype wire
